@@ hw/rtl/lqnp_pkg.sv @@
// Shared types and codes for the linear queue with negative purge.
package lqnp_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned NUM_W   = 4;
  localparam int unsigned OUT_W   = NUM_W + VALUE_W + NUM_W;

  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PURGE_RD,
    S_PURGE_CHK,
    S_FRONT_RD,
    S_REPORT
  } state_t;

endpackage

@@ hw/rtl/lqnp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module lqnp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/linear_queue_negative_purge_unit.sv @@
// Top level of the linear (non-wrapping) queue of signed words with negative purge.
//
// Usage: each input beat carries one operation in in_tuser (enqueue, dequeue or
// purge of negative entries) and, for an enqueue, the word in in_tdata. Every
// input beat produces exactly one output beat: out_tuser holds the status (done,
// refused because full, refused because empty) and out_tdata holds the entry
// count, the entry at the front (zero when empty) and the number of entries
// removed by a purge.
// The queue never wraps: once the tail has passed the last slot an enqueue is
// refused, even if dequeues have freed slots at the start.
// Timing: one beat at a time; in_tready is high only while idle. For enqueue,
// dequeue and any other code the front slot is addressed, then the registered
// RAM read is loaded into the output register, and only then is the next beat taken.
// A purge first walks the held entries through the single read port, each one
// read, then tested and compacted, and only then reads the front in the same
// way.
// The result sits in an output register, so the next beat may be accepted
// while a result still waits; a stalled receiver only holds the block once a
// second result is ready. Reset empties the queue (both indices to zero) and
// drops any pending result; the storage itself is not cleared.
module linear_queue_negative_purge_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lqnp_pkg::VALUE_W-1:0]  in_tdata,   // [31:0] value
  input  logic [lqnp_pkg::OP_W-1:0]     in_tuser,   // [1:0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lqnp_pkg::OUT_W-1:0]    out_tdata,  // [3:0] count, [35:4] front_value,
                                                    // [39:36] removed
  output logic [lqnp_pkg::STAT_W-1:0]   out_tuser   // [1:0] status
);

  import lqnp_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IDX_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

  state_t state_r, state_nxt;

  // Indices: front and tail range over 0..DEPTH, tail is exclusive.
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  // Purge read and write pointers, and the count of dropped entries.
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0] wr_r, wr_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [NUM_W-1:0]     out_count_r, out_count_nxt;
  logic [VALUE_W-1:0]   out_front_r, out_front_nxt;
  logic [NUM_W-1:0]     out_removed_r, out_removed_nxt;

  // Storage port.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic in_accept;
  logic report_load;
  logic [IDX_W-1:0]       held;
  logic [IDX_W+NUM_W-1:0] held_ext;
  logic [IDX_W+NUM_W-1:0] rem_ext;

  assign in_tready   = (state_r == S_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign report_load = (state_r == S_REPORT) && (!out_valid_r || out_tready);

  // Counts are reported modulo 16, as the result fields are four bits wide.
  assign held     = tail_r - front_r;
  assign held_ext = {{NUM_W{1'b0}}, held};
  assign rem_ext  = {{NUM_W{1'b0}}, rem_r};

  lqnp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_tuser == OP_PURGE) ? S_PURGE_RD : S_FRONT_RD;
        end
      end
      S_PURGE_RD: begin
        state_nxt = (rd_r == tail_r) ? S_FRONT_RD : S_PURGE_CHK;
      end
      S_PURGE_CHK: state_nxt = S_PURGE_RD;
      S_FRONT_RD:  state_nxt = S_REPORT;
      S_REPORT: begin
        if (report_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and storage control.
  always_comb begin
    front_nxt       = front_r;
    tail_nxt        = tail_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    rem_nxt         = rem_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_front_nxt   = out_front_r;
    out_removed_nxt = out_removed_r;
    ram_we          = 1'b0;
    ram_waddr       = tail_r[AW-1:0];
    ram_wdata       = in_tdata;
    // The front slot is addressed by default, so its data stays on the read
    // port while a result waits for the receiver.
    ram_raddr       = front_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          status_nxt = STATUS_DONE;
          rem_nxt    = '0;
          rd_nxt     = front_r;
          wr_nxt     = front_r;
          case (in_tuser)
            OP_ENQ: begin
              if (tail_r == DEPTH_IDX) begin
                status_nxt = STATUS_FULL;
              end else begin
                ram_we   = 1'b1;
                tail_nxt = tail_r + 1'b1;
              end
            end
            OP_DEQ: begin
              if (front_r == tail_r) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                front_nxt = front_r + 1'b1;
              end
            end
            default: begin
              // A purge is carried out by the following states; the unused
              // code leaves everything as it is.
            end
          endcase
        end
      end
      S_PURGE_RD: begin
        ram_raddr = rd_r[AW-1:0];
        if (rd_r == tail_r) begin
          tail_nxt = wr_r;
        end
      end
      S_PURGE_CHK: begin
        if (ram_rdata[VALUE_W-1]) begin
          rem_nxt = rem_r + 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wr_r[AW-1:0];
          ram_wdata = ram_rdata;
          wr_nxt    = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
      end
      S_REPORT: begin
        if (report_load) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_count_nxt   = held_ext[NUM_W-1:0];
          out_front_nxt   = (held != '0) ? ram_rdata : '0;
          out_removed_nxt = rem_ext[NUM_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r          <= rd_nxt;
    wr_r          <= wr_nxt;
    rem_r         <= rem_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_front_r   <= out_front_nxt;
    out_removed_r <= out_removed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_removed_r, out_front_r, out_count_r};

endmodule

@@ hw/rtl/lqnp_checker.sv @@
// Port-level assertions for the linear queue, bound to the top level.
module lqnp_port_checker #(
  parameter int unsigned DEPTH = 8
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [lqnp_pkg::OUT_W-1:0]    out_tdata,
  input logic [lqnp_pkg::STAT_W-1:0]   out_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready
);

  import lqnp_pkg::*;

  // A waiting result beat is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Every operation goes through further states, so the block is busy after a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A refused operation never reports removed entries.
  a_refused_removed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STATUS_DONE |-> out_tdata[39:36] == 4'd0)
    else $error("refused operation reports removed entries");

  // A dequeue refused as empty shows an empty queue.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_EMPTY |-> out_tdata[35:0] == 36'd0)
    else $error("empty status with nonzero count or front value");

  // With fewer than sixteen slots the count is exact, so an empty count means
  // a zero front value.
  a_zero_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (DEPTH < 16) && out_tdata[3:0] == 4'd0 |-> out_tdata[35:4] == 32'd0)
    else $error("front value shown for an empty queue");

endmodule

bind linear_queue_negative_purge_unit lqnp_port_checker #(
  .DEPTH (DEPTH)
) u_lqnp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ dv/lqnp_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of the queue, works out each result and compares it.
module lqnp_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [lqnp_pkg::VALUE_W-1:0]  in_tdata,   // [31:0] value
  input  logic [lqnp_pkg::OP_W-1:0]     in_tuser,   // [1:0] op
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [lqnp_pkg::OUT_W-1:0]    out_tdata,  // [3:0] count, [35:4] front_value,
                                                    // [39:36] removed
  input  logic [lqnp_pkg::STAT_W-1:0]   out_tuser,  // [1:0] status
  output int unsigned                   fail_count,
  output int unsigned                   results_owed
);
  import lqnp_pkg::*;

  // Same layout as {out_tuser, out_tdata}.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [NUM_W-1:0]   removed;
    logic [VALUE_W-1:0] front_value;
    logic [NUM_W-1:0]   count;
  } queue_result_t;

  logic [VALUE_W-1:0] slot [DEPTH];
  int unsigned        front_idx;
  int unsigned        tail_idx;
  queue_result_t      owed_results [$];

  // Applies one operation to the local copy of the queue and returns its result.
  function automatic queue_result_t queue_op_result(input logic [OP_W-1:0] op,
                                                    input logic [VALUE_W-1:0] word);
    queue_result_t r;
    int unsigned   rd;
    int unsigned   wr;
    int unsigned   held;
    r.status  = STATUS_DONE;
    r.removed = '0;
    case (op)
      OP_ENQ: begin
        if (tail_idx >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          slot[tail_idx] = word;
          tail_idx++;
        end
      end
      OP_DEQ: begin
        if (front_idx >= tail_idx) begin
          r.status = STATUS_EMPTY;
        end else begin
          front_idx++;
        end
      end
      OP_PURGE: begin
        wr = front_idx;
        for (rd = front_idx; rd < tail_idx; rd++) begin
          if (slot[rd][VALUE_W-1]) begin
            r.removed = r.removed + 1'b1;
          end else begin
            slot[wr] = slot[rd];
            wr++;
          end
        end
        tail_idx = wr;
      end
      default: begin
      end
    endcase
    held        = tail_idx - front_idx;
    r.count     = NUM_W'(held);
    r.front_value = (held != 0 && front_idx < DEPTH) ? slot[front_idx] : '0;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (!rst_n) begin
      front_idx  = 0;
      tail_idx   = 0;
      fail_count = 0;
      owed_results.delete();
    end else begin
      // A result always belongs to an earlier beat, so it is settled first.
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (owed_results.size() == 0) begin
          $display("%0t: result beat with none owed, actual 0x%0h", $time, got);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
          compare_field("count", VALUE_W'(want.count), VALUE_W'(got.count));
          compare_field("front_value", want.front_value, got.front_value);
          compare_field("removed", VALUE_W'(want.removed), VALUE_W'(got.removed));
        end
      end
      if (in_tvalid && in_tready) begin
        owed_results.push_back(queue_op_result(in_tuser, in_tdata));
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

@@ dv/linear_queue_negative_purge_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the queue testbench: clock, reset, stimulus, receiver back-pressure and verdict.
module linear_queue_negative_purge_unit_tb;
  import lqnp_pkg::*;

  localparam int unsigned DEPTH          = 8;
  localparam int unsigned RANDOM_BEATS   = 750;
  // Length of the single receiver hold-off, long enough for the block to fill its
  // output register, finish a second beat and stall its input.
  localparam int unsigned RX_HOLD_CYCLES = 150;
  // Settling time after the last result, several times as long as a purge of a
  // full queue takes.
  localparam int unsigned SETTLE_CYCLES  = 60;
  // Generous bound on the whole run, in nanoseconds.
  localparam int unsigned RUN_LIMIT_NS   = 5_000_000;
  // The op code that the block does not define; it must leave the queue alone.
  localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [VALUE_W-1:0]  in_tdata   = '0;   // [31:0] value
  logic [OP_W-1:0]     in_tuser   = '0;   // [1:0] op
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;         // [3:0] count, [35:4] front_value, [39:36] removed
  logic [STAT_W-1:0]   out_tuser;         // [1:0] status

  // Idle chances in percent per cycle, changed by the stimulus between phases.
  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 47;
  // The stimulus bumps hold_req to ask for a long receiver hold-off; the receiver
  // process notices the change and counts the hold-off down itself.
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  int unsigned fail_count;
  int unsigned results_owed;

  linear_queue_negative_purge_unit #(
    .DEPTH (DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lqnp_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // 10 ns period, first rising edge at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver side. Outside a hold-off it is ready at random, at the chance that the
  // current phase asks for.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Offers one beat, after a random number of idle cycles, and returns at the edge
  // at which the block takes it. in_tvalid is left high so that back-to-back beats
  // need no second assignment in the same time step.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering beats until every owed result has been taken.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Words for enqueue. Non-negative words are kept rare on purpose: the queue never
  // wraps and only a purge gives slots back, so every kept word uses up a slot for
  // good. Mostly negative words keep the queue alive for the whole run.
  function automatic logic [VALUE_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 1) begin
      return 32'h7FFF_FFFF;
    end else if (roll < 2) begin
      return '0;
    end else if (roll < 4) begin
      return $urandom() & 32'h7FFF_FFFF;
    end else if (roll < 10) begin
      return 32'h8000_0000;
    end else if (roll < 16) begin
      return '1;
    end
    return $urandom() | 32'h8000_0000;
  endfunction

  // Operation mix. A successful dequeue also uses up a slot for good, so dequeues
  // are rare enough that the front reaches the end of the array only near the end.
  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(999, 0);
    if (roll < 12) begin
      return OP_DEQ;
    end else if (roll < 60) begin
      return OP_SPARE;
    end else if (roll < 330) begin
      return OP_PURGE;
    end
    return OP_ENQ;
  endfunction

  initial begin
    int unsigned       n;
    logic [OP_W-1:0]   op;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The queue starts empty: a purge, a dequeue and the spare code
    // must all leave it alone, and the dequeue is refused as empty.
    send_beat(OP_PURGE, 32'h1234_5678);
    send_beat(OP_DEQ, 32'hFFFF_FFFF);
    send_beat(OP_SPARE, 32'h0000_0000);
    // Both extremes of the word, minus one, zero and one.
    send_beat(OP_ENQ, 32'h8000_0000);
    send_beat(OP_ENQ, 32'h7FFF_FFFF);
    send_beat(OP_ENQ, 32'hFFFF_FFFF);
    send_beat(OP_ENQ, 32'h0000_0000);
    send_beat(OP_ENQ, 32'h0000_0001);
    // Drops the two negative words, including the one at the front.
    send_beat(OP_PURGE, 32'hAAAA_AAAA);
    send_beat(OP_DEQ, 32'h5555_5555);
    // Fill up to the last slot; the next enqueue is refused as full even though
    // the first slot has been freed by the dequeue.
    send_beat(OP_ENQ, 32'hFFFF_FFFE);
    send_beat(OP_ENQ, 32'h5555_5555);
    send_beat(OP_ENQ, 32'hAAAA_AAAA);
    send_beat(OP_ENQ, 32'h0000_0002);
    send_beat(OP_ENQ, 32'h0000_0003);
    send_beat(OP_ENQ, 32'h0000_0004);
    send_beat(OP_SPARE, 32'hFFFF_FFFF);
    // Negative words in the middle of the queue, with kept words behind them.
    send_beat(OP_PURGE, 32'h0000_0000);
    send_beat(OP_ENQ, 32'h8000_0001);
    send_beat(OP_ENQ, 32'hC000_0000);
    send_beat(OP_ENQ, 32'h0000_0005);
    send_beat(OP_PURGE, 32'h8000_0000);

    // Random part in three phases of idling: the receiver idles more than the
    // sender, then the other way round, then neither idles.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) begin
        tx_idle_pct = 47;
        rx_idle_pct <= 31;
      end else if (n == 2 * RANDOM_BEATS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // Once the sender pauses until the block has handed back every result.
      if (n == RANDOM_BEATS / 2) begin
        wait_all_results();
      end
      // Once the receiver holds off for a long stretch while beats keep coming, so
      // that the block backs up and drops in_tready.
      if (n == 5 * RANDOM_BEATS / 6) begin
        hold_req <= hold_req + 1;
      end
      op = pick_op();
      send_beat(op, (op == OP_ENQ) ? pick_word() : $urandom());
    end

    // Drain by dequeues: the queue ends up empty with the indices left where they
    // are, so the slots before the front stay lost.
    for (n = 0; n < DEPTH + 2; n++) begin
      send_beat(OP_DEQ, $urandom());
    end
    send_beat(OP_ENQ, 32'h0000_0007);
    send_beat(OP_ENQ, 32'hFFFF_FFF0);
    send_beat(OP_PURGE, $urandom());
    send_beat(OP_ENQ, 32'h7FFF_FFFF);
    send_beat(OP_SPARE, $urandom());

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guards against a hang anywhere in the run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
